// File: hdl/bmw_pkg.sv
// ----------------------------------------------------------------------------
// bmw_pkg: shared types and constants
// Field widths, register indexes and a clamp helper for the masked window
// maximum-sum block.
// ----------------------------------------------------------------------------
package bmw_pkg;

  localparam int unsigned PIX_W       = 32;
  localparam int unsigned SUM_W       = 38;
  localparam int unsigned ROW_SUM_W   = 35;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned MDIM_W      = 4;
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned POS_W       = 13;   // holds any position + 1 up to 4096
  localparam int unsigned MASK_STRIDE = 8;

  localparam int unsigned DEF_MAX_SIZE      = 256;
  localparam int unsigned DEF_MAX_MASK_ROWS = 8;
  localparam int unsigned DEF_MAX_MASK_COLS = 8;

  typedef enum logic [1:0] {
    REG_MATRIX_SIZE = 2'd0,
    REG_MASK_ROWS   = 2'd1,
    REG_MASK_COLS   = 2'd2,
    REG_MASK_BITS   = 2'd3
  } reg_idx_e;

  // map 0 to 1 and anything above hi to hi
  function automatic logic [MDIM_W-1:0] clamp_dim(logic [MDIM_W-1:0] v,
                                                  logic [MDIM_W-1:0] hi);
    logic [MDIM_W-1:0] r;
    r = v;
    if (v == '0) r = MDIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// File: hdl/bmw_line_store.sv
// ----------------------------------------------------------------------------
// bmw_line_store: row line buffers
// One memory per row slot; every slot is read at the same column, the
// slot of the current row is written with the incoming value.
// ----------------------------------------------------------------------------
module bmw_line_store import bmw_pkg::*; #(
  parameter int unsigned MAX_SIZE = DEF_MAX_SIZE,
  parameter int unsigned ROWS     = DEF_MAX_MASK_ROWS,
  parameter int unsigned CW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
  parameter int unsigned SW       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SW-1:0]    wr_slot_i,
  input  logic [CW-1:0]    col_i,
  input  logic [PIX_W-1:0] wdata_i,
  output logic [PIX_W-1:0] rd_data_o [ROWS]
);

  for (genvar g = 0; g < ROWS; g++) begin : g_row
    logic [PIX_W-1:0] mem [MAX_SIZE];
    logic [PIX_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q <= mem[col_i];
        if (wr_slot_i == SW'(g)) begin
          mem[col_i] <= wdata_i;
        end
      end
    end

    assign rd_data_o[g] = rd_q;
  end

endmodule

// File: hdl/bmw_window.sv
// ----------------------------------------------------------------------------
// bmw_window: window register array and masked row sums
// Builds each new column from the line store, shifts it into the window
// and registers the masked sum of every window row.
// ----------------------------------------------------------------------------
module bmw_window import bmw_pkg::*; #(
  parameter int unsigned ROWS = DEF_MAX_MASK_ROWS,
  parameter int unsigned COLS = DEF_MAX_MASK_COLS,
  parameter int unsigned SW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                        clk_i,
  input  logic                        shift_en_i,
  input  logic                        sum_en_i,
  input  logic signed [PIX_W-1:0]     pix_i,
  input  logic [SW-1:0]               slot_i,
  input  logic [PIX_W-1:0]            rd_data_i [ROWS],
  input  logic [MDIM_W-1:0]           mr_i,
  input  logic [MDIM_W-1:0]           mc_i,
  input  logic [MASK_W-1:0]           mask_bits_i,
  output logic signed [ROW_SUM_W-1:0] row_sum_o [ROWS]
);

  logic signed [PIX_W-1:0]     col_d [ROWS];
  logic signed [PIX_W-1:0]     win_q [ROWS][COLS];
  logic signed [ROW_SUM_W-1:0] row_sum_d [ROWS];
  logic signed [ROW_SUM_W-1:0] row_sum_q [ROWS];

  // row offset k counts up from the newest row
  always_comb begin
    logic [SW:0] idx;
    idx = '0;
    for (int k = 0; k < ROWS; k++) begin
      if (k == 0) begin
        col_d[k] = pix_i;
      end else begin
        if ({1'b0, slot_i} >= (SW+1)'(k)) idx = {1'b0, slot_i} - (SW+1)'(k);
        else idx = {1'b0, slot_i} + (SW+1)'(ROWS - k);
        col_d[k] = rd_data_i[idx[SW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      for (int k = 0; k < ROWS; k++) begin
        win_q[k][0] <= col_d[k];
        for (int d = 1; d < COLS; d++) begin
          win_q[k][d] <= win_q[k][d-1];
        end
      end
    end
  end

  // window row i = mr-1-k, column j = mc-1-d; mask bit i*8+j
  always_comb begin
    logic [MDIM_W-1:0] mi;
    logic [MDIM_W-1:0] mj;
    logic [5:0]        bidx;
    mi   = '0;
    mj   = '0;
    bidx = '0;
    for (int k = 0; k < ROWS; k++) begin
      row_sum_d[k] = '0;
      mi = mr_i - MDIM_W'(1) - MDIM_W'(k);
      for (int d = 0; d < COLS; d++) begin
        mj   = mc_i - MDIM_W'(1) - MDIM_W'(d);
        bidx = {mi[2:0], mj[2:0]};
        if ((MDIM_W'(k) < mr_i) && (MDIM_W'(d) < mc_i) && mask_bits_i[bidx]) begin
          row_sum_d[k] = row_sum_d[k] + ROW_SUM_W'(win_q[k][d]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      row_sum_q <= row_sum_d;
    end
  end

  assign row_sum_o = row_sum_q;

endmodule

// File: hdl/binary_mask_window_max_sum.sv
// ----------------------------------------------------------------------------
// binary_mask_window_max_sum: greatest masked window sum over a matrix
// Streams a square matrix in raster order, sums every fitting mask window
// and returns the maximum after the last value of each matrix.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_we_i                cfg_index_i, cfg_data_i
// in       in         in_valid_i / in_ready_o pixel_value_i
// out      out        out_valid_o/out_ready_i best_window_sum_o, no_window_o
//
// One value accepted per cycle while the skid register is empty; a value
// passes the line store read, window shift and row-sum registers on its way
// to the running maximum. The line store reads all row slots at one column
// per accepted value. A skid register holds one more result; the pipeline
// halts as a whole only while a second result waits behind an untaken one.
// Reset clears counters and the maximum; line store and window need no clear.
// ----------------------------------------------------------------------------
module binary_mask_window_max_sum import bmw_pkg::*; #(
  parameter int unsigned MAX_SIZE      = DEF_MAX_SIZE,
  parameter int unsigned MAX_MASK_ROWS = DEF_MAX_MASK_ROWS,
  parameter int unsigned MAX_MASK_COLS = DEF_MAX_MASK_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [MASK_W-1:0]       cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [PIX_W-1:0] pixel_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SUM_W-1:0] best_window_sum_o,
  output logic                    no_window_o
);

  localparam int unsigned CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned SW = (MAX_MASK_ROWS > 1) ? $clog2(MAX_MASK_ROWS) : 1;

  typedef struct packed {
    logic valid;
    logic win_ok;
    logic last;
  } tag_t;

  logic [SIZE_W-1:0] size_q;
  logic [MDIM_W-1:0] mask_rows_q, mask_cols_q;
  logic [MASK_W-1:0] mask_bits_q;

  logic [CW-1:0] row_q, col_q;
  logic [SW-1:0] slot_q;
  tag_t          s1_q, s2_q, s3_q;
  logic signed [PIX_W-1:0] pix_q;
  logic [SW-1:0]           pix_slot_q;

  logic signed [SUM_W-1:0] best_q;
  logic                    any_q;
  logic                    out_valid_q, no_window_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic                    skid_q, skid_none_q;
  logic signed [SUM_W-1:0] skid_sum_q;

  logic              adv, accept, emit;
  logic [POS_W-1:0]  n, r1, c1;
  logic [MDIM_W-1:0] mr, mc;
  logic              last_col, last_row, win_ok;
  logic [PIX_W-1:0]  rd_data [MAX_MASK_ROWS];
  logic signed [ROW_SUM_W-1:0] row_sum [MAX_MASK_ROWS];
  logic signed [SUM_W-1:0]     total;
  logic signed [SUM_W-1:0]     best_d;
  logic                        any_d;
  logic signed [SUM_W-1:0]     emit_sum;
  logic                        emit_none;

  assign adv        = !skid_q;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  always_comb begin
    if (size_q == '0) n = POS_W'(1);
    else if (POS_W'(size_q) > POS_W'(MAX_SIZE)) n = POS_W'(MAX_SIZE);
    else n = POS_W'(size_q);
  end
  assign mr = clamp_dim(mask_rows_q, MDIM_W'(MAX_MASK_ROWS));
  assign mc = clamp_dim(mask_cols_q, MDIM_W'(MAX_MASK_COLS));

  assign r1       = POS_W'(row_q) + POS_W'(1);
  assign c1       = POS_W'(col_q) + POS_W'(1);
  assign last_col = (c1 >= n);
  assign last_row = (r1 >= n);
  assign win_ok   = (r1 >= POS_W'(mr)) && (c1 >= POS_W'(mc));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_W'(8);
      mask_rows_q <= MDIM_W'(1);
      mask_cols_q <= MDIM_W'(1);
      mask_bits_q <= MASK_W'(1);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MATRIX_SIZE: size_q      <= cfg_data_i[SIZE_W-1:0];
        REG_MASK_ROWS:   mask_rows_q <= cfg_data_i[MDIM_W-1:0];
        REG_MASK_COLS:   mask_cols_q <= cfg_data_i[MDIM_W-1:0];
        REG_MASK_BITS:   mask_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // raster position of the next beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      if (last_col && last_row) begin
        row_q  <= '0;
        col_q  <= '0;
        slot_q <= '0;
      end else if (last_col) begin
        col_q  <= '0;
        row_q  <= row_q + CW'(1);
        slot_q <= (slot_q == SW'(MAX_MASK_ROWS - 1)) ? '0 : slot_q + SW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  bmw_line_store #(
    .MAX_SIZE (MAX_SIZE),
    .ROWS     (MAX_MASK_ROWS)
  ) u_line_store (
    .clk_i     (clk_i),
    .en_i      (accept),
    .wr_slot_i (slot_q),
    .col_i     (col_q),
    .wdata_i   (pixel_value_i),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q      <= pixel_value_i;
      pix_slot_q <= slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv) begin
      s1_q <= '{valid: in_valid_i, win_ok: win_ok, last: last_col && last_row};
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  bmw_window #(
    .ROWS (MAX_MASK_ROWS),
    .COLS (MAX_MASK_COLS)
  ) u_window (
    .clk_i       (clk_i),
    .shift_en_i  (adv && s1_q.valid),
    .sum_en_i    (adv && s2_q.valid),
    .pix_i       (pix_q),
    .slot_i      (pix_slot_q),
    .rd_data_i   (rd_data),
    .mr_i        (mr),
    .mc_i        (mc),
    .mask_bits_i (mask_bits_q),
    .row_sum_o   (row_sum)
  );

  always_comb begin
    total = '0;
    for (int k = 0; k < MAX_MASK_ROWS; k++) begin
      total = total + SUM_W'(row_sum[k]);
    end
    best_d = best_q;
    any_d  = any_q;
    if (s3_q.win_ok) begin
      if (!any_q || total > best_q) best_d = total;
      any_d = 1'b1;
    end
  end

  assign emit      = adv && s3_q.valid && s3_q.last;
  assign emit_sum  = any_d ? best_d : '0;
  assign emit_none = !any_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= skid_q || emit;
        skid_q      <= 1'b0;
      end else if (emit) begin
        skid_q <= 1'b1;
      end
      if (adv && s3_q.valid) begin
        if (s3_q.last) begin
          // start the next matrix
          best_q <= '0;
          any_q  <= 1'b0;
        end else begin
          best_q <= best_d;
          any_q  <= any_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_q) begin
        out_sum_q   <= skid_sum_q;
        no_window_q <= skid_none_q;
      end else if (emit) begin
        out_sum_q   <= emit_sum;
        no_window_q <= emit_none;
      end
    end else if (emit) begin
      skid_sum_q  <= emit_sum;
      skid_none_q <= emit_none;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign best_window_sum_o = out_sum_q;
  assign no_window_o       = no_window_q;

endmodule

// File: hdl/bmw_checker.sv
// ----------------------------------------------------------------------------
// bmw_checker: port-level checks
// Watches the top level's ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
module bmw_checker import bmw_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [SUM_W-1:0] best_window_sum_o,
  input logic                    no_window_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_window_sum_o)
      && $stable(no_window_o))
    else $error("result changed while stalled");

  // input stalls only while a result is held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // no window means zero sum
  a_nowin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_window_o |-> best_window_sum_o == '0)
    else $error("nonzero sum with no window");

endmodule

bind binary_mask_window_max_sum bmw_checker u_bmw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .best_window_sum_o (best_window_sum_o),
  .no_window_o       (no_window_o)
);
